// File: design/fqmtf_pkg.sv
// shared types and codes for the move-to-front fifo queue
`default_nettype none

package fqmtf_pkg;

  typedef enum logic [1:0] {
    KIND_ENQ = 2'd0,
    KIND_DEQ = 2'd1,
    KIND_MTF = 2'd2
  } kind_t;

  typedef enum logic [1:0] {
    ST_OK       = 2'd0,
    ST_EMPTY    = 2'd1,
    ST_FULL     = 2'd2,
    ST_NOTFOUND = 2'd3
  } status_t;

  localparam int unsigned WORD_W = 32;
  localparam int unsigned OCC_W  = 5;

  // controller to datapath
  typedef struct packed {
    logic    ld_key;
    logic    enq_wr;
    logic    deq_pop;
    logic    rd_next;
    logic    move_wr;
    logic    head_wr;
    logic    res_ld;
    logic    res_data;
    status_t res_status;
  } cmd_t;

  // datapath to controller
  typedef struct packed {
    logic empty;
    logic full;
    logic match;
    logic at_last;
    logic idx_zero;
  } sts_t;

endpackage : fqmtf_pkg

`default_nettype wire

// File: design/fifo_queue_move_to_front_core.sv
// top level of the bounded word fifo queue with move-to-front
//
//  channel | direction | handshake            | payload
//  --------+-----------+----------------------+-------------------------------------
//  in      | input     | in_valid / in_ready  | in_kind (2), in_value (32)
//  out     | output    | out_valid / out_ready| out_data_out (32), out_status (2),
//          |           |                      | out_occupancy (5)
//
// results: enqueue, unused kind and every empty/full error give the result in the
//   cycle after the item is taken; dequeue adds one registered read of the store (S_DEQ)
// move-to-front walks the store one entry a cycle through its single read port:
//   a hit at the head ends the walk with no move, a miss reads every entry held, and a
//   deeper hit moves any later entries down (S_MOVE), then writes the key at the new head (S_HEAD)
// reset (rst_n low, synchronous) empties the queue; the store itself is not cleared
// one item at a time; a new item is taken while the last result still sits in the
//   output register only if out_ready takes it in the same cycle
`default_nettype none

module fifo_queue_move_to_front_core import fqmtf_pkg::*; #(
  parameter int unsigned DEPTH = 16
) (
  input  wire logic              clk,
  input  wire logic              rst_n,
  // item in
  input  wire logic              in_valid,
  output logic                   in_ready,
  input  wire logic [1:0]        in_kind,
  input  wire logic [WORD_W-1:0] in_value,
  // result out
  output logic                   out_valid,
  input  wire logic              out_ready,
  output logic [WORD_W-1:0]      out_data_out,
  output logic [1:0]             out_status,
  output logic [OCC_W-1:0]       out_occupancy
);

  cmd_t    cmd;
  sts_t    sts;
  status_t res_status;

  // sequencer: one-hot state machine, owns both handshakes
  fqmtf_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_kind   (in_kind),
    .out_ready (out_ready),
    .sts       (sts),
    .in_ready  (in_ready),
    .out_valid (out_valid),
    .cmd       (cmd)
  );

  // store kept as a ring: head pointer plus fill count, so dequeue never shifts;
  // move-to-front closes the gap left by the hit by moving the later entries down,
  // then steps the head back one slot and writes the key at the new head
  fqmtf_dp #(
    .DEPTH (DEPTH)
  ) u_dp (
    .clk        (clk),
    .rst_n      (rst_n),
    .cmd        (cmd),
    .in_value   (in_value),
    .sts        (sts),
    .res_data   (out_data_out),
    .res_status (res_status),
    .res_occ    (out_occupancy)
  );

  assign out_status = res_status;

endmodule : fifo_queue_move_to_front_core

`default_nettype wire

// File: design/fqmtf_dp.sv
// datapath: circular word store, pointers, search compare and result register
`default_nettype none

module fqmtf_dp import fqmtf_pkg::*; #(
  parameter int unsigned DEPTH = 16
) (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire cmd_t              cmd,
  input  wire logic [WORD_W-1:0] in_value,
  output sts_t                   sts,
  output logic [WORD_W-1:0]      res_data,
  output status_t                res_status,
  output logic [OCC_W-1:0]       res_occ
);

  localparam int unsigned PW = $clog2(DEPTH);
  localparam int unsigned CW = $clog2(DEPTH + 1);
  localparam logic [PW:0]   DEPTH_W = (PW + 1)'(DEPTH);
  localparam logic [CW-1:0] DEPTH_C = CW'(DEPTH);
  localparam logic [PW-1:0] LAST_P  = PW'(DEPTH - 1);

  // physical slot of head + offset, both below DEPTH
  function automatic logic [PW-1:0] wrap_add(input logic [PW-1:0] a, input logic [PW-1:0] b);
    logic [PW:0] sum;
    sum = {1'b0, a} + {1'b0, b};
    if (sum >= DEPTH_W) begin
      sum = sum - DEPTH_W;
    end
    return sum[PW-1:0];
  endfunction

  logic [WORD_W-1:0] mem [DEPTH];
  logic [WORD_W-1:0] rd_data_r;
  logic [WORD_W-1:0] key_r;
  logic [PW-1:0]     head_r, head_nxt;
  logic [CW-1:0]     count_r, count_nxt;
  logic [PW-1:0]     rd_idx_r, rd_idx_nxt;
  logic [PW-1:0]     rd_addr;
  logic [PW-1:0]     head_m1;
  logic              wr_en;
  logic [PW-1:0]     wr_addr;
  logic [WORD_W-1:0] wr_data;
  logic [CW-1:0]     count_m1;
  logic [WORD_W-1:0] res_data_r;
  status_t           res_status_r;
  logic [OCC_W-1:0]  res_occ_r;

  assign head_m1    = (head_r == '0) ? LAST_P : head_r - 1'b1;
  assign count_m1   = count_r - 1'b1;
  assign rd_idx_nxt = cmd.rd_next ? rd_idx_r + 1'b1 : '0;
  assign rd_addr    = wrap_add(head_r, rd_idx_nxt);

  always_comb begin
    wr_en   = 1'b0;
    wr_addr = wrap_add(head_r, PW'(count_r));
    wr_data = in_value;
    if (cmd.enq_wr) begin
      wr_en = 1'b1;
    end else if (cmd.move_wr) begin
      wr_en   = 1'b1;
      wr_addr = wrap_add(head_r, rd_idx_r - 1'b1);
      wr_data = rd_data_r;
    end else if (cmd.head_wr) begin
      wr_en   = 1'b1;
      wr_addr = head_m1;
      wr_data = key_r;
    end
  end

  always_comb begin
    head_nxt  = head_r;
    count_nxt = count_r;
    if (cmd.enq_wr) begin
      count_nxt = count_r + 1'b1;
    end
    if (cmd.deq_pop) begin
      head_nxt  = wrap_add(head_r, PW'(1));
      count_nxt = count_m1;
    end
    if (cmd.head_wr) begin
      head_nxt = head_m1;
    end
  end

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    rd_data_r <= mem[rd_addr];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      head_r  <= '0;
      count_r <= '0;
    end else begin
      head_r  <= head_nxt;
      count_r <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    rd_idx_r <= rd_idx_nxt;
    if (cmd.ld_key) begin
      key_r <= in_value;
    end
    if (cmd.res_ld) begin
      res_data_r   <= cmd.res_data ? rd_data_r : '0;
      res_status_r <= cmd.res_status;
      res_occ_r    <= OCC_W'(count_nxt);
    end
  end

  assign sts.empty    = (count_r == '0);
  assign sts.full     = (count_r == DEPTH_C);
  assign sts.match    = (rd_data_r == key_r);
  assign sts.at_last  = (CW'(rd_idx_r) == count_m1);
  assign sts.idx_zero = (rd_idx_r == '0);

  assign res_data   = res_data_r;
  assign res_status = res_status_r;
  assign res_occ    = res_occ_r;

endmodule : fqmtf_dp

`default_nettype wire

// File: design/fqmtf_ctrl.sv
// controller: sequencing of enqueue, dequeue and move-to-front, output valid
`default_nettype none

module fqmtf_ctrl import fqmtf_pkg::*; (
  input  wire logic       clk,
  input  wire logic       rst_n,
  input  wire logic       in_valid,
  input  wire logic [1:0] in_kind,
  input  wire logic       out_ready,
  input  wire sts_t       sts,
  output logic            in_ready,
  output logic            out_valid,
  output cmd_t            cmd
);

  typedef enum logic [4:0] {
    S_IDLE   = 5'b00001,
    S_DEQ    = 5'b00010,
    S_SEARCH = 5'b00100,
    S_MOVE   = 5'b01000,
    S_HEAD   = 5'b10000
  } state_t;

  state_t state_r, state_nxt;
  logic   out_valid_r, out_valid_nxt;
  logic   accept;

  assign in_ready = (state_r == S_IDLE) && (!out_valid_r || out_ready);
  assign accept   = in_valid && in_ready;

  always_comb begin
    state_nxt      = state_r;
    cmd            = '0;
    cmd.res_status = ST_OK;
    case (state_r)
      S_IDLE: begin
        if (accept) begin
          cmd.ld_key = 1'b1;
          case (kind_t'(in_kind))
            KIND_ENQ: begin
              cmd.res_ld = 1'b1;
              if (sts.full) begin
                cmd.res_status = ST_FULL;
              end else begin
                cmd.enq_wr = 1'b1;
              end
            end
            KIND_DEQ: begin
              if (sts.empty) begin
                cmd.res_ld     = 1'b1;
                cmd.res_status = ST_EMPTY;
              end else begin
                state_nxt = S_DEQ;
              end
            end
            KIND_MTF: begin
              if (sts.empty) begin
                cmd.res_ld     = 1'b1;
                cmd.res_status = ST_EMPTY;
              end else begin
                state_nxt = S_SEARCH;
              end
            end
            default: begin
              cmd.res_ld = 1'b1;
            end
          endcase
        end
      end
      S_DEQ: begin
        cmd.res_ld   = 1'b1;
        cmd.res_data = 1'b1;
        cmd.deq_pop  = 1'b1;
        state_nxt    = S_IDLE;
      end
      S_SEARCH: begin
        cmd.rd_next = 1'b1;
        if (sts.match) begin
          if (sts.idx_zero) begin
            cmd.res_ld = 1'b1;
            state_nxt  = S_IDLE;
          end else if (sts.at_last) begin
            state_nxt = S_HEAD;
          end else begin
            state_nxt = S_MOVE;
          end
        end else if (sts.at_last) begin
          cmd.res_ld     = 1'b1;
          cmd.res_status = ST_NOTFOUND;
          state_nxt      = S_IDLE;
        end
      end
      S_MOVE: begin
        cmd.rd_next = 1'b1;
        cmd.move_wr = 1'b1;
        if (sts.at_last) begin
          state_nxt = S_HEAD;
        end
      end
      S_HEAD: begin
        cmd.head_wr = 1'b1;
        cmd.res_ld  = 1'b1;
        state_nxt   = S_IDLE;
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (cmd.res_ld) begin
      out_valid_nxt = 1'b1;
    end else if (out_ready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  assign out_valid = out_valid_r;

endmodule : fqmtf_ctrl

`default_nettype wire

// File: design/fqmtf_chk.sv
// port-level checker for the move-to-front fifo queue, bound to the top level
`default_nettype none

module fqmtf_chk import fqmtf_pkg::*; #(
  parameter int unsigned DEPTH = 16
) (
  input wire logic              clk,
  input wire logic              rst_n,
  input wire logic              in_valid,
  input wire logic              in_ready,
  input wire logic [1:0]        in_kind,
  input wire logic [WORD_W-1:0] in_value,
  input wire logic              out_valid,
  input wire logic              out_ready,
  input wire logic [WORD_W-1:0] out_data_out,
  input wire logic [1:0]        out_status,
  input wire logic [OCC_W-1:0]  out_occupancy
);

  localparam logic [OCC_W-1:0] DEPTH_O = OCC_W'(DEPTH);

  // a waiting result is never dropped or altered
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_data_out)
      && $stable(out_status) && $stable(out_occupancy))
    else $error("stalled result changed");

  // no item is taken while the output register is blocked
  a_in_blocked: assert property (@(posedge clk) disable iff (!rst_n)
    in_ready |-> !out_valid || out_ready)
    else $error("item taken over a pending result");

  // full is only ever reported with the queue at capacity
  a_full_occ: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_status == ST_FULL |-> out_occupancy == DEPTH_O)
    else $error("full status with queue not at capacity");

  // empty is reported with nothing held and no data
  a_empty_occ: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_status == ST_EMPTY |-> out_occupancy == '0 && out_data_out == '0)
    else $error("empty status with entries or data");

  // occupancy never exceeds the capacity
  a_occ_max: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> DEPTH > 31 || out_occupancy <= DEPTH_O)
    else $error("occupancy above capacity");

endmodule : fqmtf_chk

bind fifo_queue_move_to_front_core fqmtf_chk #(.DEPTH(DEPTH)) u_fqmtf_chk (.*);

`default_nettype wire

// File: tb/tb_fifo_queue_move_to_front_core.sv
// testbench for the move-to-front fifo queue: directed table, random commands, self-checking
`default_nettype none

module tb_fifo_queue_move_to_front_core;
  import fqmtf_pkg::*;

  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned DEPTH        = 16;
  localparam int unsigned RANDOM_ITEMS = 1124;
  // kind 3 carries no command; the block answers with ok and the occupancy
  localparam logic [1:0]  KIND_UNUSED  = 2'd3;
  // the receiver stops taking results for a long while once this many have come
  localparam int unsigned HOLD_AT      = 400;
  localparam int unsigned HOLD_CYCLES  = 250;
  // the sender waits for the queue of expectations to drain before this item
  localparam int unsigned PAUSE_AT     = 700;
  // a hit deep in a full queue takes the longest; leave margin for the tail
  localparam int unsigned DRAIN_CYCLES = 2 * DEPTH + 8;
  localparam int unsigned CYCLE_LIMIT  = 200000;
  localparam int unsigned NUM_ROWS     = 26;

  // one result of the block
  typedef struct packed {
    logic [WORD_W-1:0] data;
    status_t           status;
    logic [OCC_W-1:0]  occ;
  } qresult_t;

  // one row of the directed table; known = expected result typed in
  typedef struct packed {
    logic [1:0]        kind;
    logic [WORD_W-1:0] value;
    logic              known;
    qresult_t          res;
  } row_t;

  logic              clk = 1'b0;
  logic              rst_n;
  logic              in_valid;
  logic              in_ready;
  logic [1:0]        in_kind;
  logic [WORD_W-1:0] in_value;
  logic              out_valid;
  logic              out_ready;
  logic [WORD_W-1:0] out_data_out;
  logic [1:0]        out_status;
  logic [OCC_W-1:0]  out_occupancy;

  // shadow copy of the queue contents, index 0 is the head
  logic [WORD_W-1:0] queue_words [$];
  // results still owed by the block, oldest first
  qresult_t          pending_results [$];
  int unsigned       mismatch_count = 0;
  int unsigned       cycle_count    = 0;
  int unsigned       items_sent     = 0;
  int unsigned       results_taken  = 0;

  // directed part: empty errors, unused kind, extreme words, signed zero and
  // nan patterns, miss, hit at head, hit at the tail, fill to full, full error
  row_t directed_rows [NUM_ROWS] = '{
    '{KIND_DEQ,    32'h0000_0000, 1'b1, '{32'h0, ST_EMPTY,    5'd0}},
    '{KIND_MTF,    32'hDEAD_BEEF, 1'b1, '{32'h0, ST_EMPTY,    5'd0}},
    '{KIND_UNUSED, 32'hFFFF_FFFF, 1'b1, '{32'h0, ST_OK,       5'd0}},
    '{KIND_ENQ,    32'h0000_0000, 1'b1, '{32'h0, ST_OK,       5'd1}},
    '{KIND_ENQ,    32'h8000_0000, 1'b1, '{32'h0, ST_OK,       5'd2}},
    '{KIND_ENQ,    32'hFFFF_FFFF, 1'b1, '{32'h0, ST_OK,       5'd3}},
    '{KIND_ENQ,    32'h7FC0_0000, 1'b1, '{32'h0, ST_OK,       5'd4}},
    '{KIND_MTF,    32'h7FC0_0000, 1'b0, '{32'h0, ST_OK,       5'd0}},
    '{KIND_MTF,    32'h8000_0000, 1'b0, '{32'h0, ST_OK,       5'd0}},
    '{KIND_MTF,    32'h8000_0000, 1'b0, '{32'h0, ST_OK,       5'd0}},
    '{KIND_MTF,    32'h3F80_0000, 1'b1, '{32'h0, ST_NOTFOUND, 5'd4}},
    '{KIND_ENQ,    32'h0000_0000, 1'b0, '{32'h0, ST_OK,       5'd0}},
    '{KIND_ENQ,    32'h5555_5555, 1'b0, '{32'h0, ST_OK,       5'd0}},
    '{KIND_ENQ,    32'hAAAA_AAAA, 1'b0, '{32'h0, ST_OK,       5'd0}},
    '{KIND_ENQ,    32'h0000_0001, 1'b0, '{32'h0, ST_OK,       5'd0}},
    '{KIND_ENQ,    32'h8000_0001, 1'b0, '{32'h0, ST_OK,       5'd0}},
    '{KIND_ENQ,    32'h8000_0000, 1'b0, '{32'h0, ST_OK,       5'd0}},
    '{KIND_ENQ,    32'h7FFF_FFFF, 1'b0, '{32'h0, ST_OK,       5'd0}},
    '{KIND_ENQ,    32'hFFFF_FFFE, 1'b0, '{32'h0, ST_OK,       5'd0}},
    '{KIND_ENQ,    32'h1234_5678, 1'b0, '{32'h0, ST_OK,       5'd0}},
    '{KIND_ENQ,    32'hFFC0_0000, 1'b0, '{32'h0, ST_OK,       5'd0}},
    '{KIND_ENQ,    32'h3F80_0000, 1'b0, '{32'h0, ST_OK,       5'd0}},
    '{KIND_ENQ,    32'h0F0F_0F0F, 1'b1, '{32'h0, ST_OK,       5'd16}},
    '{KIND_ENQ,    32'hF0F0_F0F0, 1'b1, '{32'h0, ST_FULL,     5'd16}},
    '{KIND_MTF,    32'h0F0F_0F0F, 1'b0, '{32'h0, ST_OK,       5'd0}},
    '{KIND_DEQ,    32'h0000_0000, 1'b0, '{32'h0, ST_OK,       5'd0}}
  };

  fifo_queue_move_to_front_core #(
    .DEPTH(DEPTH)
  ) i_dut (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_valid     (in_valid),
    .in_ready     (in_ready),
    .in_kind      (in_kind),
    .in_value     (in_value),
    .out_valid    (out_valid),
    .out_ready    (out_ready),
    .out_data_out (out_data_out),
    .out_status   (out_status),
    .out_occupancy(out_occupancy)
  );

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  // applies one command to the shadow queue and returns the result it gives
  function automatic qresult_t apply_command(logic [1:0] kind, logic [WORD_W-1:0] word);
    qresult_t          res;
    int                pos;
    logic [WORD_W-1:0] hit;
    res.data   = '0;
    res.status = ST_OK;
    pos        = -1;
    case (kind)
      KIND_ENQ: begin
        if (queue_words.size() >= DEPTH) res.status = ST_FULL;
        else queue_words.push_back(word);
      end
      KIND_DEQ: begin
        if (queue_words.size() == 0) res.status = ST_EMPTY;
        else res.data = queue_words.pop_front();
      end
      KIND_MTF: begin
        if (queue_words.size() == 0) begin
          res.status = ST_EMPTY;
        end else begin
          // first match from the head, bitwise
          foreach (queue_words[i]) begin
            if (pos < 0 && queue_words[i] === word) pos = i;
          end
          if (pos < 0) begin
            res.status = ST_NOTFOUND;
          end else if (pos > 0) begin
            hit = queue_words[pos];
            queue_words.delete(pos);
            queue_words.push_front(hit);
          end
        end
      end
      default: begin
      end
    endcase
    res.occ = OCC_W'(queue_words.size());
    return res;
  endfunction

  // word mix: float corner patterns, a small pool that makes duplicates, full random
  function automatic logic [WORD_W-1:0] random_word();
    logic [WORD_W-1:0] w;
    case ($urandom_range(0, 9))
      0: begin
        case ($urandom_range(0, 3))
          0: w = 32'h0000_0000;
          1: w = 32'h8000_0000;
          2: w = 32'hFFFF_FFFF;
          default: w = 32'h7FC0_0000;
        endcase
      end
      1, 2, 3: w = $urandom_range(0, 5);
      default: w = $urandom;
    endcase
    return w;
  endfunction

  // idle stretches: every fifth block of 128 items runs with no gaps at all
  function automatic int unsigned draw_gap(int unsigned n);
    if ((n / 128) % 5 == 2) return 0;
    return $urandom_range(0, 8);
  endfunction

  // presents one item from a falling edge and returns at the falling edge
  // after it was taken; the expectation is recorded at the accepting edge
  task automatic offer_item(logic [1:0] kind, logic [WORD_W-1:0] word,
                            logic known, qresult_t typed_res);
    int unsigned gap;
    qresult_t    res;
    gap = draw_gap(items_sent);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_valid <= 1'b1;
    in_kind  <= kind;
    in_value <= word;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    res = apply_command(kind, word);
    pending_results.push_back(known ? typed_res : res);
    items_sent++;
    @(negedge clk);
  endtask

  // sender: directed table, then random commands shaped by a fill trend
  initial begin
    int unsigned       trend;
    int unsigned       enq_w;
    int unsigned       deq_w;
    int unsigned       r;
    logic [1:0]        kind;
    logic [WORD_W-1:0] word;
    rst_n    = 1'b0;
    in_valid = 1'b0;
    in_kind  = '0;
    in_value = '0;
    trend    = 0;
    repeat (5) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    foreach (directed_rows[i]) begin
      offer_item(directed_rows[i].kind, directed_rows[i].value,
                 directed_rows[i].known, directed_rows[i].res);
    end

    for (int unsigned n = 0; n < RANDOM_ITEMS; n++) begin
      // switch between filling, draining and balanced phases now and then
      if (n % 48 == 0) trend = $urandom_range(0, 2);
      case (trend)
        0: begin
          enq_w = 60;
          deq_w = 15;
        end
        1: begin
          enq_w = 15;
          deq_w = 60;
        end
        default: begin
          enq_w = 35;
          deq_w = 30;
        end
      endcase
      r = $urandom_range(0, 99);
      if (r < 4) kind = KIND_UNUSED;
      else begin
        r = $urandom_range(0, 99);
        if (r < enq_w) kind = KIND_ENQ;
        else if (r < enq_w + deq_w) kind = KIND_DEQ;
        else kind = KIND_MTF;
      end
      // keys mostly taken from the queue, so that hits at any depth occur
      if (kind == KIND_MTF && queue_words.size() > 0 && $urandom_range(0, 9) < 7)
        word = queue_words[$urandom_range(0, queue_words.size() - 1)];
      else
        word = random_word();

      // sender stops until the block has delivered everything it owes
      if (items_sent == PAUSE_AT) begin
        in_valid <= 1'b0;
        while (pending_results.size() != 0) @(posedge clk);
        @(negedge clk);
      end
      offer_item(kind, word, 1'b0, '0);
    end

    in_valid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (mismatch_count == 0) begin
      $display("PASSED: all results match");
    end else begin
      $display("FAILED: results differ");
    end
    $finish;
  end

  // receiver: random stalls, one long hold-off so the block backs up
  initial begin
    int unsigned gap;
    out_ready = 1'b0;
    @(negedge clk);
    while (!rst_n) @(negedge clk);
    forever begin
      if (results_taken == HOLD_AT) begin
        out_ready <= 1'b0;
        repeat (HOLD_CYCLES) @(negedge clk);
      end else begin
        gap = draw_gap(results_taken);
        if (gap > 0) begin
          out_ready <= 1'b0;
          repeat (gap) @(negedge clk);
        end
      end
      out_ready <= 1'b1;
      @(posedge clk);
      while (!out_valid) @(posedge clk);
      results_taken++;
      @(negedge clk);
    end
  end

  // result checker against the oldest expectation
  always @(posedge clk) begin
    qresult_t want;
    if (rst_n && out_valid && out_ready) begin
      if (pending_results.size() == 0) begin
        $error("result with nothing expected: data_out %0h status %0d occupancy %0d",
               out_data_out, out_status, out_occupancy);
        mismatch_count++;
      end else begin
        want = pending_results.pop_front();
        if (out_data_out !== want.data) begin
          $error("data_out: expected %0h, got %0h", want.data, out_data_out);
          mismatch_count++;
        end
        if (out_status !== want.status) begin
          $error("status: expected %0d, got %0d", want.status, out_status);
          mismatch_count++;
        end
        if (out_occupancy !== want.occ) begin
          $error("occupancy: expected %0d, got %0d", want.occ, out_occupancy);
          mismatch_count++;
        end
      end
    end
  end

  // run limit
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("FAILED: results differ");
      $finish;
    end
  end

endmodule

`default_nettype wire
